FILE: src/lpd_pkg.sv
// shared types, constants and the line position table of the line tracking drive
package lpd_pkg;

	localparam int SENSOR_COUNT = 5;
	localparam int DEV_W        = 7;
	localparam int DUTY_W       = 10;
	localparam int CORR_W       = 11;
	localparam int REQ_W        = 12;
	localparam int GAIN_W       = 12;
	localparam int MS_W         = 16;
	localparam int TIME_W       = 32;
	localparam int ACC_W        = 22;
	localparam int PROD_W       = 21;
	localparam int IDX_W        = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int IN_DATA_W    = 40;
	localparam int OUT_DATA_W   = 64;

	localparam logic [GAIN_W-1:0] PROP_GAIN_RST   = 12'd288;
	localparam logic [GAIN_W-1:0] DERIV_GAIN_RST  = 12'd720;
	localparam logic [DUTY_W-1:0] CRUISE_DUTY_RST = 10'd300;
	localparam logic [DUTY_W-1:0] CORR_LIMIT_RST  = 10'd800;
	localparam logic [DUTY_W-1:0] DUTY_LIMIT_RST  = 10'd1000;
	localparam logic [DUTY_W-1:0] KICK_DUTY_RST   = 10'd800;
	localparam logic [MS_W-1:0]   KICK_MS_RST     = 16'd50;

	typedef enum logic [IDX_W-1:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_DERIV_GAIN  = 3'd1,
		REG_CRUISE_DUTY = 3'd2,
		REG_CORR_LIMIT  = 3'd3,
		REG_DUTY_LIMIT  = 3'd4,
		REG_KICK_DUTY   = 3'd5,
		REG_KICK_MS     = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] prop_gain;
		logic [GAIN_W-1:0] deriv_gain;
		logic [DUTY_W-1:0] cruise_duty;
		logic [DUTY_W-1:0] correction_limit;
		logic [DUTY_W-1:0] duty_limit;
		logic [DUTY_W-1:0] kick_duty;
		logic [MS_W-1:0]   kick_ms;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEV,
		ST_MUL_P,
		ST_MUL_D,
		ST_CORR,
		ST_DRIVE
	} state_t;

	typedef struct packed {
		logic load;
		logic dev_en;
		logic mul_p;
		logic mul_d;
		logic corr_en;
		logic drive_en;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

	// mean of the active sensor weights, truncated toward zero
	function automatic logic signed [DEV_W-1:0] dev_lookup(input logic [SENSOR_COUNT-1:0] s);
		logic signed [DEV_W-1:0] d;
		case (s)
			5'd1:  d = 7'sd43;
			5'd2:  d = 7'sd15;
			5'd3:  d = 7'sd29;
			5'd4:  d = 7'sd0;
			5'd5:  d = 7'sd21;
			5'd6:  d = 7'sd7;
			5'd7:  d = 7'sd19;
			5'd8:  d = -7'sd15;
			5'd9:  d = 7'sd14;
			5'd10: d = 7'sd0;
			5'd11: d = 7'sd14;
			5'd12: d = -7'sd7;
			5'd13: d = 7'sd9;
			5'd14: d = 7'sd0;
			5'd15: d = 7'sd10;
			5'd16: d = -7'sd43;
			5'd17: d = 7'sd0;
			5'd18: d = -7'sd14;
			5'd19: d = 7'sd5;
			5'd20: d = -7'sd21;
			5'd21: d = 7'sd0;
			5'd22: d = -7'sd9;
			5'd23: d = 7'sd3;
			5'd24: d = -7'sd29;
			5'd25: d = -7'sd5;
			5'd26: d = -7'sd14;
			5'd27: d = 7'sd0;
			5'd28: d = -7'sd19;
			5'd29: d = -7'sd3;
			5'd30: d = -7'sd10;
			default: d = 7'sd0;
		endcase
		return d;
	endfunction

endpackage

FILE: src/lpd_cfg.sv
// configuration register file of the line tracking drive
module lpd_cfg import lpd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain        <= PROP_GAIN_RST;
			cfg_q.deriv_gain       <= DERIV_GAIN_RST;
			cfg_q.cruise_duty      <= CRUISE_DUTY_RST;
			cfg_q.correction_limit <= CORR_LIMIT_RST;
			cfg_q.duty_limit       <= DUTY_LIMIT_RST;
			cfg_q.kick_duty        <= KICK_DUTY_RST;
			cfg_q.kick_ms          <= KICK_MS_RST;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_PROP_GAIN:   cfg_q.prop_gain        <= cfg_data[GAIN_W-1:0];
				REG_DERIV_GAIN:  cfg_q.deriv_gain       <= cfg_data[GAIN_W-1:0];
				REG_CRUISE_DUTY: cfg_q.cruise_duty      <= cfg_data[DUTY_W-1:0];
				REG_CORR_LIMIT:  cfg_q.correction_limit <= cfg_data[DUTY_W-1:0];
				REG_DUTY_LIMIT:  cfg_q.duty_limit       <= cfg_data[DUTY_W-1:0];
				REG_KICK_DUTY:   cfg_q.kick_duty        <= cfg_data[DUTY_W-1:0];
				REG_KICK_MS:     cfg_q.kick_ms          <= cfg_data[MS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: src/lpd_ctrl.sv
// step sequencer of the line tracking drive
module lpd_ctrl import lpd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_DEV;
			ST_DEV:   state_d = ST_MUL_P;
			ST_MUL_P: state_d = ST_MUL_D;
			ST_MUL_D: state_d = ST_CORR;
			ST_CORR:  state_d = ST_DRIVE;
			ST_DRIVE: if (status.out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_DEV:   cmd.dev_en   = 1'b1;
			ST_MUL_P: cmd.mul_p    = 1'b1;
			ST_MUL_D: cmd.mul_d    = 1'b1;
			ST_CORR:  cmd.corr_en  = 1'b1;
			ST_DRIVE: cmd.drive_en = status.out_free;
			default: ;
		endcase
	end

endmodule

FILE: src/lpd_dp.sv
// datapath of the line tracking drive: deviation, shared pd multiplier, wheel drive
module lpd_dp import lpd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  cmd_t                  cmd,
	output status_t               status,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata
);

	logic [SENSOR_COUNT-1:0] sensors_q;
	logic [TIME_W-1:0]       now_q;
	logic                    half_q;
	logic                    stop_q;
	logic                    clear_q;

	logic signed [DEV_W-1:0]  dev_q;
	logic signed [DEV_W-1:0]  prev_dev_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [CORR_W-1:0] corr_q;
	logic signed [REQ_W-1:0]  prev_left_q;
	logic signed [REQ_W-1:0]  prev_right_q;
	logic [TIME_W-1:0]        left_start_q;
	logic [TIME_W-1:0]        right_start_q;
	logic                     out_valid_q;
	logic [OUT_DATA_W-1:0]    out_data_q;

	logic signed [DEV_W-1:0]  dev_new;
	logic signed [DEV_W:0]    diff;
	logic signed [DEV_W:0]    mul_a;
	logic signed [GAIN_W:0]   mul_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  acc_adj;
	logic signed [ACC_W-1:0]  acc_q16;
	logic signed [ACC_W-1:0]  corr_lim;
	logic signed [ACC_W-1:0]  corr_sat;
	logic [DUTY_W-1:0]        base;
	logic signed [REQ_W-1:0]  left_req;
	logic signed [REQ_W-1:0]  right_req;
	logic signed [REQ_W-1:0]  left_cmd;
	logic signed [REQ_W-1:0]  right_cmd;
	logic [DUTY_W-1:0]        lf_duty, lr_duty, rf_duty, rr_duty;

	function automatic logic signed [REQ_W-1:0] wheel_cmd(
		input logic signed [REQ_W-1:0] req,
		input logic signed [REQ_W-1:0] prev,
		input logic [TIME_W-1:0]       start,
		input logic [TIME_W-1:0]       now,
		input cfg_t                    c
	);
		logic [TIME_W-1:0]       elapsed;
		logic                    kick;
		logic signed [REQ_W-1:0] v;
		logic signed [REQ_W-1:0] lim;
		elapsed = (prev == '0) ? '0 : now - start;
		kick    = (req != '0) && (elapsed < {{(TIME_W-MS_W){1'b0}}, c.kick_ms});
		v       = req;
		if (kick) begin
			v = (req > 0) ? $signed({2'b00, c.kick_duty}) : -$signed({2'b00, c.kick_duty});
		end
		lim = $signed({2'b00, c.duty_limit});
		if (v > lim) begin
			v = lim;
		end else if (v < -lim) begin
			v = -lim;
		end
		return v;
	endfunction

	function automatic logic [DUTY_W-1:0] fwd_part(input logic signed [REQ_W-1:0] v);
		return (v > 0) ? v[DUTY_W-1:0] : '0;
	endfunction

	function automatic logic [DUTY_W-1:0] rev_part(input logic signed [REQ_W-1:0] v);
		logic signed [REQ_W-1:0] n;
		n = -v;
		return (v < 0) ? n[DUTY_W-1:0] : '0;
	endfunction

	// deviation, holding the last one when no sensor sees the line, or zero when history is cleared
	always_comb begin
		if (sensors_q == '0) begin
			dev_new = clear_q ? '0 : prev_dev_q;
		end else begin
			dev_new = dev_lookup(sensors_q);
		end
	end

	// one shared multiplier: proportional step, then derivative step
	assign diff  = {dev_q[DEV_W-1], dev_q} - {prev_dev_q[DEV_W-1], prev_dev_q};
	assign mul_a = cmd.mul_d ? diff : {dev_q[DEV_W-1], dev_q};
	assign mul_b = cmd.mul_d ? $signed({1'b0, cfg.deriv_gain}) : $signed({1'b0, cfg.prop_gain});
	assign prod  = mul_a * mul_b;

	// divide by 16 toward zero, then saturate
	always_comb begin
		acc_adj  = acc_q + (acc_q[ACC_W-1] ? 22'sd15 : 22'sd0);
		acc_q16  = acc_adj >>> 4;
		corr_lim = $signed({{(ACC_W-DUTY_W){1'b0}}, cfg.correction_limit});
		corr_sat = acc_q16;
		if (acc_q16 > corr_lim) begin
			corr_sat = corr_lim;
		end else if (acc_q16 < -corr_lim) begin
			corr_sat = -corr_lim;
		end
	end

	always_comb begin
		base = half_q ? {1'b0, cfg.cruise_duty[DUTY_W-1:1]} : cfg.cruise_duty;
		if (stop_q) begin
			left_req  = '0;
			right_req = '0;
		end else begin
			left_req  = $signed({2'b00, base}) + REQ_W'(corr_q);
			right_req = $signed({2'b00, base}) - REQ_W'(corr_q);
		end
		left_cmd  = wheel_cmd(left_req, prev_left_q, left_start_q, now_q, cfg);
		right_cmd = wheel_cmd(right_req, prev_right_q, right_start_q, now_q, cfg);
		lf_duty   = fwd_part(left_cmd);
		lr_duty   = rev_part(left_cmd);
		rf_duty   = fwd_part(right_cmd);
		rr_duty   = rev_part(right_cmd);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sensors_q <= s_tdata[4:0];
			now_q     <= s_tdata[36:5];
			half_q    <= s_tdata[37];
			stop_q    <= s_tdata[38];
			clear_q   <= s_tdata[39];
		end
		if (cmd.dev_en) begin
			dev_q <= dev_new;
		end
		if (cmd.mul_p) begin
			acc_q <= ACC_W'(prod);
		end else if (cmd.mul_d) begin
			acc_q <= acc_q + ACC_W'(prod);
		end
		if (cmd.corr_en) begin
			corr_q <= stop_q ? '0 : corr_sat[CORR_W-1:0];
		end
		if (cmd.drive_en) begin
			out_data_q <= {6'b0, corr_q, dev_q, rr_duty, rf_duty, lr_duty, lf_duty};
		end
	end

	// state carried between items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_dev_q    <= '0;
			prev_left_q   <= '0;
			prev_right_q  <= '0;
			left_start_q  <= '0;
			right_start_q <= '0;
		end else begin
			if (cmd.dev_en && clear_q) begin
				prev_dev_q <= '0;
			end else if (cmd.corr_en && !stop_q) begin
				prev_dev_q <= dev_q;
			end
			if (cmd.drive_en) begin
				prev_left_q  <= left_req;
				prev_right_q <= right_req;
				if (left_req != '0 && prev_left_q == '0) begin
					left_start_q <= now_q;
				end
				if (right_req != '0 && prev_right_q == '0) begin
					right_start_q <= now_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.drive_en) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.out_free = !out_valid_q || m_tready;
	assign m_tvalid        = out_valid_q;
	assign m_tdata         = out_data_q;

endmodule

FILE: src/line_tracking_pd_drive.sv
// top level of the line tracking pd differential drive
// One control tick is taken per input transaction and gives one result transaction.
// An item passes from acceptance to a loaded result through a sequencer that steps
// through deviation lookup, two passes of one shared 8x13 multiplier for the
// proportional and derivative terms, scaling and saturation of the correction,
// and the wheel stage with kick-start and clamping. The next item is accepted in
// the cycle after the result is loaded into the output register. The result waits
// while the previous one is not taken, so only one item is in flight at a time.
// Configuration writes are accepted in every cycle and are meant for idle times.
module line_tracking_pd_drive import lpd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// line_sensors[4:0], now_ms[36:5], half_speed[37], motors_stop[38], clear_history[39]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// left_forward_duty[9:0], left_reverse_duty[19:10], right_forward_duty[29:20],
	// right_reverse_duty[39:30], line_deviation[46:40], steer_correction[57:47], zero[63:58]
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	lpd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lpd_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.status   (status),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

FILE: src/lpd_checker.sv
// port level checks of the line tracking drive and their binding
module lpd_checker import lpd_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one item in flight: no acceptance right after an acceptance
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted on consecutive cycles");

	// a wheel never drives forward and reverse together
	a_split: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[9:0] == '0 || m_tdata[19:10] == '0) &&
		             (m_tdata[29:20] == '0 || m_tdata[39:30] == '0))
		else $error("forward and reverse duty both set");

	// deviation within the weight range and padding clear
	a_dev_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[46:40]) <= 7'sd43) &&
		             ($signed(m_tdata[46:40]) >= -7'sd43) && (m_tdata[63:58] == '0))
		else $error("deviation out of range or padding set");

endmodule

bind line_tracking_pd_drive lpd_checker u_lpd_checker (.*);

FILE: verif/testbench.sv
// self-checking testbench for the line tracking pd differential drive
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lpd_pkg::*;

	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int SENSOR_WEIGHT [SENSOR_COUNT] = '{43, 15, 0, -15, -43};
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic              clear_history;
		logic              motors_stop;
		logic              half_speed;
		logic [TIME_W-1:0] now_ms;
		logic [4:0]        line_sensors;
	} tick_t;

	typedef struct packed {
		logic [5:0]               pad;
		logic signed [CORR_W-1:0] steer_correction;
		logic signed [DEV_W-1:0]  line_deviation;
		logic [DUTY_W-1:0]        right_reverse;
		logic [DUTY_W-1:0]        right_forward;
		logic [DUTY_W-1:0]        left_reverse;
		logic [DUTY_W-1:0]        left_forward;
	} drive_out_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [IDX_W-1:0]      cfg_index = REG_PROP_GAIN;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	cfg_t shadow_cfg = '{
		prop_gain: PROP_GAIN_RST, deriv_gain: DERIV_GAIN_RST, cruise_duty: CRUISE_DUTY_RST,
		correction_limit: CORR_LIMIT_RST, duty_limit: DUTY_LIMIT_RST,
		kick_duty: KICK_DUTY_RST, kick_ms: KICK_MS_RST
	};

	int                last_dev = 0;
	int                last_left_req = 0;
	int                last_right_req = 0;
	logic [TIME_W-1:0] left_kick_t0 = '0;
	logic [TIME_W-1:0] right_kick_t0 = '0;
	logic [TIME_W-1:0] ms_clock = 32'hFFFF_FFC0;

	drive_out_t predicted_drive [$];
	int         fault_count = 0;
	int         hold_cycles = 0;
	bit         steady = 1'b0;

	line_tracking_pd_drive u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int clamp_mag(input int v, input int lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	// kick-start and clamp of one wheel
	function automatic int wheel_command(input int req, inout int prev_req,
			inout logic [TIME_W-1:0] kick_t0, input logic [TIME_W-1:0] now);
		int                cmd;
		int                kd;
		logic [TIME_W-1:0] elapsed;
		cmd = req;
		kd = shadow_cfg.kick_duty;
		if (req != 0) begin
			if (prev_req == 0) kick_t0 = now;
			elapsed = now - kick_t0;
			if (elapsed < shadow_cfg.kick_ms) cmd = (req > 0) ? kd : -kd;
		end
		prev_req = req;
		return clamp_mag(cmd, shadow_cfg.duty_limit);
	endfunction

	function automatic drive_out_t predict_drive(input tick_t t);
		drive_out_t r;
		int wsum, active, dev, acc, base, corr;
		int pg, dg, left_req, right_req, left_cmd, right_cmd;
		wsum = 0;
		active = 0;
		corr = 0;
		left_req = 0;
		right_req = 0;
		if (t.clear_history) last_dev = 0;
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			if (t.line_sensors[i]) begin
				wsum += SENSOR_WEIGHT[i];
				active++;
			end
		end
		dev = (active == 0) ? last_dev : wsum / active;
		if (!t.motors_stop) begin
			pg = shadow_cfg.prop_gain;
			dg = shadow_cfg.deriv_gain;
			acc = dev * pg + (dev - last_dev) * dg;
			base = t.half_speed ? shadow_cfg.cruise_duty >> 1 : shadow_cfg.cruise_duty;
			last_dev = dev;
			corr = clamp_mag(acc / 16, shadow_cfg.correction_limit);
			left_req = base + corr;
			right_req = base - corr;
		end
		left_cmd = wheel_command(left_req, last_left_req, left_kick_t0, t.now_ms);
		right_cmd = wheel_command(right_req, last_right_req, right_kick_t0, t.now_ms);
		r = '0;
		r.left_forward = (left_cmd > 0) ? DUTY_W'(left_cmd) : '0;
		r.left_reverse = (left_cmd < 0) ? DUTY_W'(-left_cmd) : '0;
		r.right_forward = (right_cmd > 0) ? DUTY_W'(right_cmd) : '0;
		r.right_reverse = (right_cmd < 0) ? DUTY_W'(-right_cmd) : '0;
		r.line_deviation = DEV_W'(dev);
		r.steer_correction = CORR_W'(corr);
		return r;
	endfunction

	function automatic tick_t make_tick(input logic [4:0] sensors, input int unsigned step,
			input bit half, input bit stop, input bit clear);
		tick_t t;
		ms_clock += step;
		t.line_sensors = sensors;
		t.now_ms = ms_clock;
		t.half_speed = half;
		t.motors_stop = stop;
		t.clear_history = clear;
		return t;
	endfunction

	// mostly a tracked line with steady ticks, with lost line, noise and time jumps
	function automatic tick_t random_tick();
		logic [4:0]  sensors;
		int unsigned step;
		int          pick;
		int          idx;
		pick = $urandom_range(99);
		if (pick < 60) begin
			idx = $urandom_range(4);
			sensors = 5'd1 << idx;
			if (idx < 4 && $urandom_range(1) == 1) sensors[idx + 1] = 1'b1;
		end else if (pick < 75) begin
			sensors = '0;
		end else begin
			sensors = 5'($urandom);
		end
		pick = $urandom_range(99);
		if (pick < 85) begin
			step = $urandom_range(20);
		end else if (pick < 95) begin
			step = $urandom_range(2000);
		end else begin
			ms_clock = $urandom;
			step = 0;
		end
		return make_tick(sensors, step, $urandom_range(99) < 30, $urandom_range(99) < 12,
			$urandom_range(99) < 6);
	endfunction

	function automatic cfg_t random_settings();
		cfg_t c;
		c.prop_gain = ($urandom_range(1) == 1) ? GAIN_W'($urandom_range(400)) : GAIN_W'($urandom);
		c.deriv_gain = ($urandom_range(1) == 1) ? GAIN_W'($urandom_range(800)) : GAIN_W'($urandom);
		c.cruise_duty = DUTY_W'($urandom_range(1000));
		c.correction_limit = ($urandom_range(2) == 0) ? c.cruise_duty
			: DUTY_W'($urandom_range(1000));
		c.duty_limit = DUTY_W'($urandom_range(1000));
		c.kick_duty = DUTY_W'($urandom_range(1000));
		c.kick_ms = ($urandom_range(3) == 0) ? MS_W'($urandom) : MS_W'($urandom_range(120));
		return c;
	endfunction

	task automatic send_tick(input tick_t t);
		if (!steady) begin
			while ($urandom_range(99) < 23) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= t;
		do @(posedge clk); while (!s_tready);
		predicted_drive.push_back(predict_drive(t));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (predicted_drive.size() != 0);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PROP_GAIN:   shadow_cfg.prop_gain = val[GAIN_W-1:0];
			REG_DERIV_GAIN:  shadow_cfg.deriv_gain = val[GAIN_W-1:0];
			REG_CRUISE_DUTY: shadow_cfg.cruise_duty = val[DUTY_W-1:0];
			REG_CORR_LIMIT:  shadow_cfg.correction_limit = val[DUTY_W-1:0];
			REG_DUTY_LIMIT:  shadow_cfg.duty_limit = val[DUTY_W-1:0];
			REG_KICK_DUTY:   shadow_cfg.kick_duty = val[DUTY_W-1:0];
			REG_KICK_MS:     shadow_cfg.kick_ms = val[MS_W-1:0];
			default: ;
		endcase
	endtask

	// unused upper data bits carry noise, the index past the list must be ignored
	task automatic load_settings(input cfg_t c);
		write_reg(REG_PROP_GAIN, {4'($urandom), c.prop_gain});
		write_reg(REG_DERIV_GAIN, {4'($urandom), c.deriv_gain});
		write_reg(REG_CRUISE_DUTY, {6'($urandom), c.cruise_duty});
		write_reg(REG_CORR_LIMIT, {6'($urandom), c.correction_limit});
		write_reg(REG_DUTY_LIMIT, {6'($urandom), c.duty_limit});
		write_reg(REG_KICK_DUTY, {6'($urandom), c.kick_duty});
		write_reg(REG_KICK_MS, c.kick_ms);
		write_reg(REG_UNUSED, 16'($urandom));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic void compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			fault_count++;
		end
	endfunction

	always @(posedge clk) begin : drive_check
		drive_out_t got;
		drive_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (predicted_drive.size() == 0) begin
				$display("%0t: unexpected drive result, expected none actual %h", $time, m_tdata);
				fault_count++;
			end else begin
				want = predicted_drive.pop_front();
				compare_field("left_forward_duty", want.left_forward, got.left_forward);
				compare_field("left_reverse_duty", want.left_reverse, got.left_reverse);
				compare_field("right_forward_duty", want.right_forward, got.right_forward);
				compare_field("right_reverse_duty", want.right_reverse, got.right_reverse);
				compare_field("line_deviation", want.line_deviation, got.line_deviation);
				compare_field("steer_correction", want.steer_correction,
					got.steer_correction);
				compare_field("padding", want.pad, got.pad);
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles--;
			end else begin
				m_tready <= steady || ($urandom_range(99) >= 23);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Verification failed");
		$finish;
	end

	// line positions, lost line, stop, clear, half speed and kick across the time wrap
	task automatic test_reset_defaults();
		send_tick(make_tick(5'b00100, 10, 0, 0, 0));
		send_tick(make_tick(5'b00001, 10, 0, 0, 0));
		send_tick(make_tick(5'b00010, 10, 0, 0, 0));
		send_tick(make_tick(5'b01000, 10, 0, 0, 0));
		send_tick(make_tick(5'b10000, 10, 0, 0, 0));
		send_tick(make_tick(5'b00000, 10, 0, 0, 0));
		send_tick(make_tick(5'b00000, 10, 0, 0, 1));
		send_tick(make_tick(5'b11111, 10, 0, 0, 0));
		send_tick(make_tick(5'b00011, 10, 0, 0, 0));
		send_tick(make_tick(5'b11000, 10, 0, 0, 0));
		send_tick(make_tick(5'b10001, 10, 0, 0, 0));
		send_tick(make_tick(5'b00001, 10, 0, 1, 0));
		send_tick(make_tick(5'b10000, 10, 0, 0, 0));
		send_tick(make_tick(5'b10000, 10, 1, 0, 0));
		send_tick(make_tick(5'b00110, 10, 1, 0, 0));
		send_tick(make_tick(5'b01100, 0, 0, 0, 0));
		send_tick(make_tick(5'b00000, 10, 0, 1, 1));
		send_tick(make_tick(5'b00001, 3000, 0, 0, 0));
		send_tick(make_tick(5'b10101, 10, 0, 0, 0));
		send_tick(make_tick(5'b01010, 10, 0, 0, 1));
	endtask

	task automatic test_register_extremes();
		cfg_t corner [3];
		corner[0] = '{prop_gain: 12'd4095, deriv_gain: 12'd4095, cruise_duty: 10'd1000,
			correction_limit: 10'd1000, duty_limit: 10'd1000, kick_duty: 10'd1000,
			kick_ms: 16'hFFFF};
		corner[1] = '0;
		corner[2] = '{prop_gain: 12'd4095, deriv_gain: 12'd0, cruise_duty: 10'd1000,
			correction_limit: 10'd1000, duty_limit: 10'd0, kick_duty: 10'd1000,
			kick_ms: 16'd0};
		for (int k = 0; k < 3; k++) begin
			wait_drained();
			load_settings(corner[k]);
			repeat (15) send_tick(random_tick());
		end
	endtask

	task automatic test_random_settings();
		repeat (5) begin
			wait_drained();
			load_settings(random_settings());
			repeat (60) send_tick(random_tick());
		end
	endtask

	task automatic test_steady_stream();
		wait_drained();
		load_settings(random_settings());
		steady = 1'b1;
		repeat (90) send_tick(random_tick());
		steady = 1'b0;
	endtask

	task automatic test_output_backpressure();
		wait_drained();
		hold_cycles = 200;
		repeat (40) send_tick(random_tick());
	endtask

	task automatic test_sender_pause();
		repeat (3) begin
			repeat (20) send_tick(random_tick());
			wait_drained();
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_register_extremes();
		test_random_settings();
		test_steady_stream();
		test_output_backpressure();
		test_sender_pause();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

endmodule

FILE: files.f
src/lpd_pkg.sv
src/lpd_cfg.sv
src/lpd_ctrl.sv
src/lpd_dp.sv
src/line_tracking_pd_drive.sv
src/lpd_checker.sv
verif/testbench.sv
